// ===== rtl/core/ascii_coordinate_line_parser_defines.svh =====
// Assertion macros for the ASCII coordinate line parser.
// Included by the RTL files that carry assertions; no dependencies.
`ifndef ASCII_COORDINATE_LINE_PARSER_DEFINES_SVH
`define ASCII_COORDINATE_LINE_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked at every clock edge outside of reset.
`define ACLP_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// Condition in one cycle implies a consequence in the next cycle.
`define ACLP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ACLP_ASSERT(lbl, prop, msg)
`define ACLP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== rtl/core/aclp_pkg.sv =====
// Shared constants and control types for the ASCII coordinate line parser.
// No dependencies.
package aclp_pkg;

   localparam int DEFAULT_LINE_CHARS = 32;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam logic [31:0] MAG_CAP = 32'h8000_0000;
   localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;
   localparam int          NONE_LEN = 4;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic store;  // append the accepted byte to the line store
      logic start;  // newline accepted: begin a scan of the stored line
      logic step;   // scan in progress: fetch the next character
      logic emit;   // load the output register with the parsed result
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_done;  // every stored character has been consumed
      logic result_ok;  // the scanned line gives a result
      logic rsp_free;   // the output register can take a new item
   } status_type;

endpackage

// ===== rtl/core/aclp_datapath.sv =====
// Datapath of the ASCII coordinate line parser: line store, scan pointer,
// syntax recognizer, decimal accumulator and output register. Uses aclp_pkg.
`include "ascii_coordinate_line_parser_defines.svh"

module aclp_datapath #(
   parameter int LINE_CHARS = aclp_pkg::DEFAULT_LINE_CHARS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_rx_byte,
   input  aclp_pkg::cmd_type    cmd,
   output aclp_pkg::status_type status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic signed [31:0]   rsp_x_offset,
   output logic signed [31:0]   rsp_y_offset,
   output logic                 rsp_target_seen
);

   localparam int IDX_W = $clog2(LINE_CHARS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(LINE_CHARS - 1);

   typedef enum logic [8:0] {
      SYN_LEAD  = 9'b0_0000_0001,
      SYN_XSIGN = 9'b0_0000_0010,
      SYN_XDIG  = 9'b0_0000_0100,
      SYN_XSP   = 9'b0_0000_1000,
      SYN_YLEAD = 9'b0_0001_0000,
      SYN_YSIGN = 9'b0_0010_0000,
      SYN_YDIG  = 9'b0_0100_0000,
      SYN_TAIL  = 9'b0_1000_0000,
      SYN_FAIL  = 9'b1_0000_0000
   } syn_state_type;

   function automatic logic [7:0] none_char(input logic [1:0] idx);
      logic [7:0] c;
      case (idx)
         2'd0:    c = 8'h6E;
         2'd1:    c = 8'h6F;
         2'd2:    c = 8'h6E;
         2'd3:    c = 8'h65;
         default: c = aclp_pkg::CH_NUL;
      endcase
      return c;
   endfunction

   // Magnitude and sign to two's complement, clipping the positive side.
   function automatic logic [31:0] to_value(input logic [31:0] mag, input logic neg);
      logic [31:0] v;
      if (neg) begin
         v = 32'd0 - mag;
      end else if (mag > aclp_pkg::POS_MAX) begin
         v = aclp_pkg::POS_MAX;
      end else begin
         v = mag;
      end
      return v;
   endfunction

   logic [7:0]       line_mem [LINE_CHARS];

   logic [IDX_W-1:0] fill_ff, fill_in;
   logic [IDX_W-1:0] scan_len_ff, scan_len_in;
   logic [IDX_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [7:0]       char_ff;
   logic             char_vld_ff, char_vld_in;
   logic             ended_ff, ended_in;
   syn_state_type    syn_ff, syn_in;
   logic [31:0]      acc_ff, acc_in;
   logic             neg_ff, neg_in;
   logic [31:0]      x_val_ff, x_val_in;
   logic [2:0]       none_cnt_ff, none_cnt_in;
   logic             none_ok_ff, none_ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_x_ff, rsp_x_in;
   logic [31:0]      rsp_y_ff, rsp_y_in;
   logic             rsp_seen_ff, rsp_seen_in;

   logic             rd_fire;
   logic             is_dig;
   logic [3:0]       dig_full;
   logic [34:0]      acc_next;
   logic [31:0]      acc_sat;
   logic             none_hit;

   assign rd_fire  = cmd.step && (rd_ptr_ff != scan_len_ff);
   assign is_dig   = (char_ff >= aclp_pkg::CH_ZERO) && (char_ff <= aclp_pkg::CH_NINE);
   assign dig_full = 4'(char_ff - aclp_pkg::CH_ZERO);
   assign acc_next = {acc_ff, 3'b000} + {2'b00, acc_ff, 1'b0} + {31'd0, dig_full};
   assign acc_sat  = (acc_next > {3'b000, aclp_pkg::MAG_CAP}) ? aclp_pkg::MAG_CAP
                                                              : acc_next[31:0];
   assign none_hit = none_ok_ff && (none_cnt_ff == 3'(aclp_pkg::NONE_LEN));

   // Line store: one write port for incoming bytes, one registered read for the scan.
   always_ff @(posedge clock) begin
      if (cmd.store && (fill_ff != LAST_IDX)) begin
         line_mem[fill_ff] <= req_rx_byte;
      end
      if (rd_fire) begin
         char_ff <= line_mem[rd_ptr_ff];
      end
   end

   always_comb begin
      fill_in     = fill_ff;
      scan_len_in = scan_len_ff;
      rd_ptr_in   = rd_ptr_ff;
      char_vld_in = rd_fire;
      if (cmd.start) begin
         fill_in     = '0;
         scan_len_in = fill_ff;
         rd_ptr_in   = '0;
         char_vld_in = 1'b0;
      end else begin
         if (cmd.store) begin
            fill_in = (fill_ff == LAST_IDX) ? '0 : fill_ff + 1'b1;
         end
         if (rd_fire) begin
            rd_ptr_in = rd_ptr_ff + 1'b1;
         end
      end
   end

   // Syntax recognizer, fed one character per cycle.
   always_comb begin
      ended_in    = ended_ff;
      syn_in      = syn_ff;
      acc_in      = acc_ff;
      neg_in      = neg_ff;
      x_val_in    = x_val_ff;
      none_cnt_in = none_cnt_ff;
      none_ok_in  = none_ok_ff;
      if (cmd.start) begin
         ended_in    = 1'b0;
         syn_in      = SYN_LEAD;
         acc_in      = '0;
         neg_in      = 1'b0;
         none_cnt_in = '0;
         none_ok_in  = 1'b1;
      end else if (char_vld_ff && !ended_ff) begin
         if (char_ff == aclp_pkg::CH_NUL) begin
            ended_in = 1'b1;
         end else begin
            if (none_cnt_ff == 3'(aclp_pkg::NONE_LEN)) begin
               none_ok_in = 1'b0;
            end else begin
               if (char_ff != none_char(none_cnt_ff[1:0])) begin
                  none_ok_in = 1'b0;
               end
               none_cnt_in = none_cnt_ff + 3'd1;
            end
            case (syn_ff)
               SYN_LEAD, SYN_YLEAD: begin
                  if (char_ff == aclp_pkg::CH_SP) begin
                     syn_in = syn_ff;
                  end else if (char_ff == aclp_pkg::CH_MINUS) begin
                     neg_in = 1'b1;
                     syn_in = (syn_ff == SYN_YLEAD) ? SYN_YSIGN : SYN_XSIGN;
                  end else if (char_ff == aclp_pkg::CH_PLUS) begin
                     syn_in = (syn_ff == SYN_YLEAD) ? SYN_YSIGN : SYN_XSIGN;
                  end else if (is_dig) begin
                     acc_in = acc_sat;
                     syn_in = (syn_ff == SYN_YLEAD) ? SYN_YDIG : SYN_XDIG;
                  end else begin
                     syn_in = SYN_FAIL;
                  end
               end
               SYN_XSIGN, SYN_YSIGN: begin
                  if (is_dig) begin
                     acc_in = acc_sat;
                     syn_in = (syn_ff == SYN_YSIGN) ? SYN_YDIG : SYN_XDIG;
                  end else begin
                     syn_in = SYN_FAIL;
                  end
               end
               SYN_XDIG, SYN_XSP: begin
                  if (is_dig && (syn_ff == SYN_XDIG)) begin
                     acc_in = acc_sat;
                  end else if (char_ff == aclp_pkg::CH_SP) begin
                     syn_in = SYN_XSP;
                  end else if (char_ff == aclp_pkg::CH_COMMA) begin
                     x_val_in = to_value(acc_ff, neg_ff);
                     acc_in   = '0;
                     neg_in   = 1'b0;
                     syn_in   = SYN_YLEAD;
                  end else begin
                     syn_in = SYN_FAIL;
                  end
               end
               SYN_YDIG: begin
                  if (is_dig) begin
                     acc_in = acc_sat;
                  end else if (char_ff == aclp_pkg::CH_SP) begin
                     syn_in = SYN_TAIL;
                  end else begin
                     syn_in = SYN_FAIL;
                  end
               end
               SYN_TAIL: begin
                  if (char_ff != aclp_pkg::CH_SP) begin
                     syn_in = SYN_FAIL;
                  end
               end
               SYN_FAIL: begin
                  syn_in = SYN_FAIL;
               end
               default: begin
                  syn_in = SYN_FAIL;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_seen_in  = rsp_seen_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (none_hit) begin
            rsp_x_in    = '0;
            rsp_y_in    = '0;
            rsp_seen_in = 1'b0;
         end else begin
            rsp_x_in    = x_val_ff;
            rsp_y_in    = to_value(acc_ff, neg_ff);
            rsp_seen_in = 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         scan_len_ff  <= '0;
         rd_ptr_ff    <= '0;
         char_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         syn_ff       <= SYN_LEAD;
      end else begin
         fill_ff      <= fill_in;
         scan_len_ff  <= scan_len_in;
         rd_ptr_ff    <= rd_ptr_in;
         char_vld_ff  <= char_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         syn_ff       <= syn_in;
      end
   end

   always_ff @(posedge clock) begin
      ended_ff    <= ended_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      x_val_ff    <= x_val_in;
      none_cnt_ff <= none_cnt_in;
      none_ok_ff  <= none_ok_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_seen_ff <= rsp_seen_in;
   end

   assign status.scan_done = (rd_ptr_ff == scan_len_ff) && !char_vld_ff;
   assign status.result_ok = none_hit || (syn_ff == SYN_YDIG) || (syn_ff == SYN_TAIL);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_x_offset    = $signed(rsp_x_ff);
   assign rsp_y_offset    = $signed(rsp_y_ff);
   assign rsp_target_seen = rsp_seen_ff;

   `ACLP_ASSERT(a_none_zero, rsp_valid_ff && !rsp_seen_ff |-> rsp_x_ff == 32'd0 && rsp_y_ff == 32'd0, "absent target with nonzero coordinates")
   `ACLP_ASSERT(a_scan_bound, rd_ptr_ff <= scan_len_ff, "scan pointer ran past the line length")
   `ACLP_ASSERT_NEXT(a_start_clears, cmd.start, fill_ff == '0 && syn_ff == SYN_LEAD && !char_vld_ff, "scan start did not reset the line")

endmodule

// ===== rtl/core/aclp_controller.sv =====
// Controller of the ASCII coordinate line parser: accepts bytes, runs the
// line scan and hands the result to the output register. Uses aclp_pkg.
`include "ascii_coordinate_line_parser_defines.svh"

module aclp_controller (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [7:0]           req_rx_byte,
   input  aclp_pkg::status_type status,
   output aclp_pkg::cmd_type    cmd
);

   typedef enum logic [2:0] {
      CTL_IDLE = 3'b001,
      CTL_SCAN = 3'b010,
      CTL_EMIT = 3'b100
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic          accept;

   assign accept = req_valid && req_ready;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         CTL_IDLE: begin
            req_ready = 1'b1;
            if (accept) begin
               if (req_rx_byte == aclp_pkg::CH_LF) begin
                  cmd.start = 1'b1;
                  state_in  = CTL_SCAN;
               end else if (req_rx_byte != aclp_pkg::CH_CR) begin
                  cmd.store = 1'b1;
               end
            end
         end
         CTL_SCAN: begin
            cmd.step = 1'b1;
            if (status.scan_done) begin
               state_in = status.result_ok ? CTL_EMIT : CTL_IDLE;
            end
         end
         CTL_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ACLP_ASSERT(a_emit_free, cmd.emit |-> status.rsp_free, "result loaded over a pending item")
   `ACLP_ASSERT_NEXT(a_start_scans, cmd.start, state_ff == CTL_SCAN, "newline did not start a scan")

endmodule

// ===== rtl/core/ascii_coordinate_line_parser.sv =====
// ASCII coordinate line parser. Ordinary bytes are taken one per cycle and
// the block stays ready for them. A newline starts a scan of the stored
// line, one character per cycle from the line store's read port; input is
// held off during the scan and while the result waits to be loaded into the
// output register. A line that does not parse gives no result.
// Synchronous active-high reset empties the line and clears the output valid.
module ascii_coordinate_line_parser #(
   parameter int LINE_CHARS = aclp_pkg::DEFAULT_LINE_CHARS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_x_offset,
   output logic signed [31:0] rsp_y_offset,
   output logic               rsp_target_seen
);

   // The controller decides when bytes are stored and when the stored line
   // is scanned; it sees the input byte only to tell newline and carriage
   // return apart from text. Carriage returns are accepted and dropped.
   aclp_pkg::cmd_type    cmd;
   aclp_pkg::status_type status;

   aclp_controller u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .status      (status),
      .cmd         (cmd)
   );

   // The datapath holds up to LINE_CHARS - 1 characters. A byte that arrives
   // when the store is full is dropped and the line restarts empty. During the
   // scan a recognizer walks the text, stopping at a zero byte, and accepts
   // either the word "none" or two signed decimals separated by a comma with
   // optional spaces. Decimal magnitudes saturate at the 32-bit limits. The
   // result sits in an output register so that new bytes are taken while it
   // waits to be read.
   aclp_datapath #(
      .LINE_CHARS (LINE_CHARS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .req_rx_byte     (req_rx_byte),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_x_offset    (rsp_x_offset),
      .rsp_y_offset    (rsp_y_offset),
      .rsp_target_seen (rsp_target_seen)
   );

endmodule
